// ===== rtl/core/roff_esc_pkg.sv =====
package roff_esc_pkg;

  localparam int unsigned ByteW = 8;

  // Configuration register indexes
  localparam logic CFG_SINGLE_LINE = 1'b0;
  localparam logic CFG_LITERAL     = 1'b1;

  // Character codes used by the escaper
  localparam logic [ByteW-1:0] CH_NL    = 8'h0A;
  localparam logic [ByteW-1:0] CH_SPACE = 8'h20;
  localparam logic [ByteW-1:0] CH_DQUOTE = 8'h22;
  localparam logic [ByteW-1:0] CH_AMP   = 8'h26;
  localparam logic [ByteW-1:0] CH_APOS  = 8'h27;
  localparam logic [ByteW-1:0] CH_LPAR  = 8'h28;
  localparam logic [ByteW-1:0] CH_DOT   = 8'h2E;
  localparam logic [ByteW-1:0] CH_BSL   = 8'h5C;
  localparam logic [ByteW-1:0] CH_CARET = 8'h5E;
  localparam logic [ByteW-1:0] CH_BTICK = 8'h60;
  localparam logic [ByteW-1:0] CH_TILDE = 8'h7E;
  localparam logic [ByteW-1:0] CH_A     = 8'h61;
  localparam logic [ByteW-1:0] CH_D     = 8'h64;
  localparam logic [ByteW-1:0] CH_E     = 8'h65;
  localparam logic [ByteW-1:0] CH_G     = 8'h67;
  localparam logic [ByteW-1:0] CH_H     = 8'h68;
  localparam logic [ByteW-1:0] CH_I     = 8'h69;
  localparam logic [ByteW-1:0] CH_Q     = 8'h71;
  localparam logic [ByteW-1:0] CH_T     = 8'h74;

  // Kind of output run for one input byte
  typedef enum logic [1:0] {
    KIND_PLAIN  = 2'd0,  // byte as is
    KIND_BSLASH = 2'd1,  // \e
    KIND_GUARD  = 2'd2,  // \& then byte
    KIND_SEQ    = 2'd3   // \( then two letters
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [ByteW-1:0] ch;
  } desc_t;

  typedef struct packed {
    logic single_line;
    logic literal;
  } cfg_t;

  typedef logic [1:0] run_idx_t;

  // Index of the last byte of a run
  function automatic run_idx_t run_last_idx(kind_t kind);
    run_idx_t res;
    case (kind)
      KIND_PLAIN:  res = 2'd0;
      KIND_BSLASH: res = 2'd1;
      KIND_GUARD:  res = 2'd2;
      KIND_SEQ:    res = 2'd3;
      default:     res = 2'd0;
    endcase
    return res;
  endfunction

  // First and second letters of a named-character escape
  function automatic logic [ByteW-1:0] seq_letter(logic [ByteW-1:0] ch, logic second);
    logic [ByteW-1:0] res;
    case (ch)
      CH_CARET: res = second ? CH_A : CH_H;
      CH_TILDE: res = second ? CH_I : CH_T;
      CH_BTICK: res = second ? CH_A : CH_G;
      default:  res = second ? CH_Q : CH_D;
    endcase
    return res;
  endfunction

  // Byte at position idx of the run for a descriptor
  function automatic logic [ByteW-1:0] run_byte(desc_t d, run_idx_t idx);
    logic [ByteW-1:0] res;
    res = d.ch;
    case (d.kind)
      KIND_PLAIN:  res = d.ch;
      KIND_BSLASH: res = (idx == 2'd0) ? CH_BSL : CH_E;
      KIND_GUARD: begin
        case (idx)
          2'd0:    res = CH_BSL;
          2'd1:    res = CH_AMP;
          default: res = d.ch;
        endcase
      end
      KIND_SEQ: begin
        case (idx)
          2'd0:    res = CH_BSL;
          2'd1:    res = CH_LPAR;
          2'd2:    res = seq_letter(d.ch, 1'b0);
          default: res = seq_letter(d.ch, 1'b1);
        endcase
      end
      default: res = d.ch;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/core/roff_esc_if.sv =====
interface roff_esc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       call_start;
  logic       prior_newline;

  modport source (output valid, output in_byte, output call_start,
                  output prior_newline, input ready);
  modport sink   (input valid, input in_byte, input call_start,
                  input prior_newline, output ready);
endinterface

interface roff_esc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

// ===== rtl/core/roff_esc_front.sv =====
module roff_esc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  roff_esc_pkg::cfg_t    cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic                  call_start,
  input  logic                  prior_newline,
  input  logic                  q_full,
  output logic                  q_push,
  output roff_esc_pkg::desc_t   q_desc
);
  import roff_esc_pkg::*;

  logic  at_line_start_r, at_line_start_nxt;
  logic  skipping_r, skipping_nxt;
  logic  eff_line_start, eff_skip, drop, accept;
  desc_t desc;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Apply string start before classifying
  assign eff_line_start = call_start ? prior_newline : at_line_start_r;
  assign eff_skip       = call_start ? (!cfg.literal && prior_newline) : skipping_r;
  assign drop = eff_skip && ((in_byte == CH_SPACE) || (in_byte == CH_NL));

  // Classify the byte and compute the next line state
  always_comb begin
    desc.kind         = KIND_PLAIN;
    desc.ch           = in_byte;
    at_line_start_nxt = 1'b0;
    skipping_nxt      = 1'b0;
    if (drop) begin
      at_line_start_nxt = eff_line_start;
      skipping_nxt      = eff_skip;
    end else begin
      case (in_byte) inside
        CH_CARET, CH_TILDE, CH_BTICK, CH_DQUOTE: desc.kind = KIND_SEQ;
        CH_BSL: desc.kind = KIND_BSLASH;
        CH_NL: begin
          desc.ch           = cfg.single_line ? CH_SPACE : CH_NL;
          at_line_start_nxt = !cfg.single_line;
          skipping_nxt      = !cfg.literal;
        end
        CH_DOT, CH_APOS: begin
          if (!cfg.single_line && eff_line_start) begin
            desc.kind = KIND_GUARD;
          end
        end
        default: desc.kind = KIND_PLAIN;
      endcase
    end
  end

  assign q_push = accept && !drop;
  assign q_desc = desc;

  // Hold line state between transactions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_line_start_r <= 1'b0;
      skipping_r      <= 1'b0;
    end else if (accept) begin
      at_line_start_r <= at_line_start_nxt;
      skipping_r      <= skipping_nxt;
    end
  end

endmodule

// ===== rtl/core/roff_esc_fifo.sv =====
module roff_esc_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  roff_esc_pkg::desc_t  push_data,
  output logic                 full,
  input  logic                 pop,
  output roff_esc_pkg::desc_t  pop_data,
  output logic                 empty
);
  import roff_esc_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  desc_t           mem [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            do_push, do_pop;

  assign full     = (count_r == FullCnt);
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  // Write storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/roff_esc_back.sv =====
module roff_esc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  roff_esc_pkg::desc_t  q_desc,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 run_last
);
  import roff_esc_pkg::*;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       run_last_r;
  run_idx_t   idx_r;
  logic       load, emit, last;

  assign load = !out_valid_r || out_ready;
  assign emit = load && !q_empty;
  assign last = (idx_r == run_last_idx(q_desc.kind));
  assign q_pop = emit && last;

  // Step through the run of the head descriptor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= !q_empty;
      if (emit) begin
        idx_r <= last ? '0 : idx_r + 1'b1;
      end
    end
  end

  // Load output payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= run_byte(q_desc, idx_r);
      run_last_r <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign run_last  = run_last_r;

endmodule

// ===== rtl/core/roff_text_escaper.sv =====
// Roff text escaper. Takes one text byte per transaction on in_ch and emits
// a run of one to four bytes on out_ch, the last marked by run_last; bytes
// dropped as leading blanks emit nothing. A plain stream flows at one byte per
// cycle while out_ch.ready stays high; an escaped byte expands to a run of two
// bytes for \e, three for a dot or apostrophe behind the \& guard or four for
// \(xx, sent one byte at a time from the output register. A queue of
// QUEUE_DEPTH classified bytes between the input classifier and the output
// expander absorbs these runs, and in_ch.ready drops only when that queue is
// full. Configuration writes (index 0 single-line mode, index 1 literal
// mode, bit 0 of cfg_wdata) are meant for idle periods and take effect on
// the next accepted byte.
module roff_text_escaper #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic                 cfg_wdata,
  roff_esc_in_if.sink          in_ch,
  roff_esc_out_if.source       out_ch
);
  import roff_esc_pkg::*;

  cfg_t  cfg_r;
  desc_t push_desc, head_desc;
  logic  q_push, q_pop, q_full, q_empty;
  logic  out_first_r;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SINGLE_LINE: cfg_r.single_line <= cfg_wdata;
        CFG_LITERAL:     cfg_r.literal     <= cfg_wdata;
        default:         cfg_r             <= cfg_r;
      endcase
    end
  end

  roff_esc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_byte       (in_ch.in_byte),
    .call_start    (in_ch.call_start),
    .prior_newline (in_ch.prior_newline),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_desc        (push_desc)
  );

  roff_esc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (head_desc),
    .empty     (q_empty)
  );

  roff_esc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_desc    (head_desc),
    .q_pop     (q_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .run_last  (out_ch.run_last)
  );

  // Track whether the next output byte opens a run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_first_r <= 1'b1;
    end else if (out_ch.valid && out_ch.ready) begin
      out_first_r <= out_ch.run_last;
    end
  end

  // A multi-byte run always opens with a backslash
  a_run_opens_escape: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_first_r && !out_ch.run_last |-> out_ch.out_byte == CH_BSL)
    else $error("multi-byte run does not open with backslash");

  // A run continues without a gap once started
  a_run_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.run_last |=> out_ch.valid)
    else $error("gap inside an output run");

  // Input stalls only while output is backed up
  a_stall_means_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with no pending output");

endmodule

// ===== tb/sv/roff_escape_checker.sv =====
`timescale 1ns / 1ps

module roff_escape_checker (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    cfg_we,
  input  logic    cfg_index,
  input  logic    cfg_wdata,
  roff_esc_in_if  in_ch,
  roff_esc_out_if out_ch,
  output int      mismatch_count,
  output int      bytes_pending,
  output int      runs_predicted
);
  import roff_esc_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             run_last;
  } esc_byte_t;

  // Escaped bytes still owed by the block, oldest first
  esc_byte_t escaped_q[$];

  // Shadow of the mode registers and of the line state
  logic single_line = 1'b0;
  logic literal     = 1'b0;
  logic line_start  = 1'b0;
  logic skip_blank  = 1'b0;

  int errors = 0;
  int runs   = 0;

  // Escape one text byte and queue the run it produces
  task automatic escape_text_byte(input logic [ByteW-1:0] b, input logic start,
                                  input logic prior);
    logic [31:0] seq;
    int          len;
    logic        guard;
    esc_byte_t   e;
    seq = '0;
    len = 1;
    if (start) begin
      line_start = prior;
      skip_blank = !literal && prior;
    end
    // Drop leading blanks without touching the state
    if (skip_blank && (b == CH_SPACE || b == CH_NL)) return;
    skip_blank = 1'b0;
    guard = !single_line && line_start;
    line_start = 1'b0;
    case (b)
      CH_CARET: begin
        seq = {CH_BSL, CH_LPAR, CH_H, CH_A};
        len = 4;
      end
      CH_TILDE: begin
        seq = {CH_BSL, CH_LPAR, CH_T, CH_I};
        len = 4;
      end
      CH_BTICK: begin
        seq = {CH_BSL, CH_LPAR, CH_G, CH_A};
        len = 4;
      end
      CH_DQUOTE: begin
        seq = {CH_BSL, CH_LPAR, CH_D, CH_Q};
        len = 4;
      end
      CH_BSL: begin
        seq = {CH_BSL, CH_E, 16'h0000};
        len = 2;
      end
      CH_NL: begin
        seq = {(single_line ? CH_SPACE : CH_NL), 24'h000000};
        line_start = !single_line;
        skip_blank = !literal;
      end
      CH_DOT, CH_APOS: begin
        // Guard a control character that would open a line
        if (guard) begin
          seq = {CH_BSL, CH_AMP, b, 8'h00};
          len = 3;
        end else begin
          seq = {b, 24'h000000};
        end
      end
      default: seq = {b, 24'h000000};
    endcase
    for (int i = 0; i < len; i++) begin
      e.out_byte = seq[31-8*i -: 8];
      e.run_last = (i == len - 1);
      escaped_q.push_back(e);
    end
    runs++;
  endtask

  always @(posedge clk) begin : watch
    esc_byte_t want;
    if (!rst_n) begin
      single_line = 1'b0;
      literal     = 1'b0;
      line_start  = 1'b0;
      skip_blank  = 1'b0;
      escaped_q.delete();
    end else begin
      // Compare each output transaction with the oldest expected byte
      if (out_ch.valid && out_ch.ready) begin
        if (escaped_q.size() == 0) begin
          $error("unexpected output byte %h (run_last %b)", out_ch.out_byte,
                 out_ch.run_last);
          errors++;
        end else begin
          want = escaped_q.pop_front();
          if (out_ch.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, out_ch.out_byte);
            errors++;
          end
          if (out_ch.run_last !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, out_ch.run_last);
            errors++;
          end
        end
      end
      // Predict the run for each input transaction
      if (in_ch.valid && in_ch.ready) begin
        escape_text_byte(in_ch.in_byte, in_ch.call_start, in_ch.prior_newline);
      end
      // Track mode register writes, seen from the next transaction on
      if (cfg_we) begin
        case (cfg_index)
          CFG_SINGLE_LINE: single_line = cfg_wdata;
          CFG_LITERAL:     literal     = cfg_wdata;
          default: ;
        endcase
      end
    end
    mismatch_count <= errors;
    bytes_pending  <= escaped_q.size();
    runs_predicted <= runs;
  end

endmodule

// ===== tb/sv/roff_text_escaper_test.sv =====
`timescale 1ns / 1ps

module roff_text_escaper_test;
  import roff_esc_pkg::*;

  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 24;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic cfg_wdata;

  roff_esc_in_if  in_ch ();
  roff_esc_out_if out_ch ();

  int mismatch_count;
  int bytes_pending;
  int runs_predicted;
  int cycle_count  = 0;
  int bytes_sent   = 0;
  int settings_run = 0;
  bit quiet        = 1'b0;

  roff_text_escaper i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  roff_escape_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatch_count),
    .bytes_pending  (bytes_pending),
    .runs_predicted (runs_predicted)
  );

  always #1 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL roff_text_escaper");
      $finish;
    end
  end

  // Idle cycles before one transaction on either side
  function automatic int draw_wait();
    if (quiet) return 0;
    return $urandom_range(0, 13);
  endfunction

  // Stall the output side per transaction
  initial begin : receiver
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
        stall = 0;
      end else if (out_ch.ready && out_ch.valid) begin
        stall = draw_wait();
        if (stall != 0) out_ch.ready <= 1'b0;
      end else if (!out_ch.ready) begin
        if (stall <= 1) out_ch.ready <= 1'b1;
        else stall--;
      end
    end
  end

  // Offer one text byte and hold it until accepted
  task automatic send_byte(input logic [ByteW-1:0] b, input logic start,
                           input logic prior);
    int gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.in_byte       <= b;
    in_ch.call_start    <= start;
    in_ch.prior_newline <= prior;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Hold off input until every expected byte has come out
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (bytes_pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_modes(input logic single, input logic lit);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SINGLE_LINE;
    cfg_wdata <= single;
    @(posedge clk);
    cfg_index <= CFG_LITERAL;
    cfg_wdata <= lit;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // Text byte weighted toward the characters that get escaped
  function automatic logic [ByteW-1:0] pick_text_byte();
    logic [ByteW-1:0] b;
    case ($urandom_range(0, 15))
      0, 1, 2, 3: b = ByteW'($urandom_range(0, 255));
      4, 5:       b = CH_SPACE;
      6, 7:       b = CH_NL;
      8:          b = CH_DOT;
      9:          b = CH_APOS;
      10:         b = CH_CARET;
      11:         b = CH_TILDE;
      12:         b = CH_BTICK;
      13:         b = CH_DQUOTE;
      14:         b = CH_BSL;
      default:    b = CH_A + ByteW'($urandom_range(0, 25));
    endcase
    return b;
  endfunction

  // Send strings of random text until enough runs have been predicted
  task automatic run_random_text(input int runs_wanted);
    int   target;
    int   left;
    logic start;
    target = runs_predicted + runs_wanted;
    left = 0;
    while (runs_predicted < target) begin
      if ($urandom_range(0, 15) == 0) quiet = ($urandom_range(0, 2) == 0);
      start = 1'b0;
      if (left == 0) begin
        left = $urandom_range(1, 12);
        start = 1'b1;
      end
      left--;
      send_byte(pick_text_byte(), start, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    in_ch.valid         <= 1'b0;
    in_ch.in_byte       <= '0;
    in_ch.call_start    <= 1'b0;
    in_ch.prior_newline <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_SINGLE_LINE;
    cfg_wdata           <= 1'b0;
    rst_n               <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed text at the reset modes
    send_byte(CH_DOT,    1'b1, 1'b0);
    send_byte(CH_SPACE,  1'b1, 1'b1);
    send_byte(CH_NL,     1'b0, 1'b0);
    send_byte(CH_DOT,    1'b0, 1'b1);
    send_byte(CH_CARET,  1'b0, 1'b0);
    send_byte(CH_TILDE,  1'b0, 1'b1);
    send_byte(CH_BTICK,  1'b0, 1'b0);
    send_byte(CH_DQUOTE, 1'b0, 1'b0);
    send_byte(CH_BSL,    1'b0, 1'b0);
    send_byte(CH_NL,     1'b0, 1'b0);
    send_byte(CH_SPACE,  1'b0, 1'b0);
    send_byte(CH_APOS,   1'b0, 1'b0);
    send_byte(8'h00,     1'b0, 1'b0);
    send_byte(8'hFF,     1'b0, 1'b0);
    send_byte(CH_NL,     1'b0, 1'b0);
    send_byte(8'h80,     1'b0, 1'b0);
    send_byte(CH_A,      1'b1, 1'b1);
    send_byte(CH_NL,     1'b1, 1'b0);
    send_byte(CH_DOT,    1'b0, 1'b0);
    send_byte(8'h7F,     1'b0, 1'b0);

    // Sweep every mode setting, with one drain mid-stream
    wait_idle();
    write_modes(1'b0, 1'b0);
    run_random_text(20);
    wait_idle();
    run_random_text(15);
    wait_idle();
    write_modes(1'b1, 1'b0);
    run_random_text(35);
    wait_idle();
    write_modes(1'b0, 1'b1);
    run_random_text(35);
    wait_idle();
    write_modes(1'b1, 1'b1);
    run_random_text(35);
    repeat (3) begin
      wait_idle();
      write_modes(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      run_random_text(15);
    end
    wait_idle();

    $display("Sent %0d text bytes yielding %0d escape runs over %0d mode settings",
             bytes_sent, runs_predicted, settings_run);
    $display("Covered escapes, line guards, blank dropping and both stall sides");
    if (mismatch_count == 0 && bytes_pending == 0) begin
      $display("PASS roff_text_escaper");
    end else begin
      $display("FAIL roff_text_escaper");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/roff_esc_pkg.sv
rtl/core/roff_esc_if.sv
rtl/core/roff_esc_front.sv
rtl/core/roff_esc_fifo.sv
rtl/core/roff_esc_back.sv
rtl/core/roff_text_escaper.sv
tb/sv/roff_escape_checker.sv
tb/sv/roff_text_escaper_test.sv
